### sv/cdt_pkg.sv
`default_nettype none

package cdt_pkg;

  localparam int MaxColsDefault = 128;
  localparam int MaxRowsDefault = 128;

  localparam int DistW   = 16;
  localparam int DimW    = 8;
  localparam int CoordW  = 7;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 1;

  localparam logic [DistW-1:0] FarMark      = 16'hFFFF;
  localparam logic [DimW-1:0]  DimResetVal  = 8'd128;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CEN,
    ST_CHK,
    ST_NB
  } state_e;

endpackage

`default_nettype wire

### sv/cdt_ram.sv
`default_nettype none

module cdt_ram #(
  parameter int Width = 16,
  parameter int Depth = 16384,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/chessboard_distance_transform.sv
`default_nettype none

// Chessboard distance transform over an on-chip pixel store of MAX_ROWS x MAX_COLS entries.
// A load or read transaction is accepted while busy is low and its result strobes on done_o
// in the next cycle, so loads and reads can follow each other every cycle while no run is
// active. A run transaction walks the image in use twice (forward raster, then backward
// raster) through the single read port of the store: a background pixel takes a centre read
// and a check per pass, a foreground pixel a centre read, four neighbour reads and a write
// back on the last, with busy staying high throughout. Results cannot be held off: done_o is
// high for exactly one cycle per transaction and the fields are valid only in that cycle.
// Pixels never loaded read back undefined. The image size registers may only change while
// busy is low and no result is pending.
module chessboard_distance_transform #(
  parameter int MAX_COLS = cdt_pkg::MaxColsDefault,
  parameter int MAX_ROWS = cdt_pkg::MaxRowsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cdt_pkg::DimW-1:0]      cfg_data_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cdt_pkg::ModeW-1:0]     mode_i,
  input  wire logic [cdt_pkg::CoordW-1:0]    pixel_row_i,
  input  wire logic [cdt_pkg::CoordW-1:0]    pixel_col_i,
  input  wire logic [cdt_pkg::DistW-1:0]     pixel_value_i,
  output logic                               done_o,
  output logic      [cdt_pkg::DistW-1:0]     distance_o,
  output logic      [cdt_pkg::DistW-1:0]     max_distance_o,
  output logic                               unreachable_o
);

  import cdt_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [1:0] NbLast = 2'd3;

  function automatic logic [AW-1:0] pix_addr(input logic [DimW-1:0] r,
                                             input logic [DimW-1:0] c);
    return AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  state_e state_q, state_d;
  logic             bwd_q, bwd_d;
  logic [DimW-1:0]  row_q, row_d, col_q, col_d;
  logic [1:0]       nb_q, nb_d;
  logic             nb_ok_q, nb_ok_d;
  logic [DistW-1:0] cur_q, cur_d;
  logic             any_fg_q, any_fg_d, any_bg_q, any_bg_d;
  logic [DistW-1:0] best_q, best_d;
  logic [DistW-1:0] largest_q, largest_d;
  logic             unreach_q, unreach_d;
  logic             done_q, done_d;
  logic             rd_sel_q, rd_sel_d;
  logic [DimW-1:0]  width_q, height_q;

  logic [DimW-1:0]  w_eff, h_eff;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DistW-1:0] ram_wdata, ram_rdata;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimResetVal;
      height_q <= DimResetVal;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = DimW'(1);
    end else if (32'(width_q) > MAX_COLS) begin
      w_eff = DimW'(MAX_COLS);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DimW'(1);
    end else if (32'(height_q) > MAX_ROWS) begin
      h_eff = DimW'(MAX_ROWS);
    end else begin
      h_eff = height_q;
    end
  end

  // raster stepping
  logic            pass_end;
  logic [DimW-1:0] nxt_row, nxt_col;

  always_comb begin
    if (!bwd_q) begin
      pass_end = (row_q == h_eff - DimW'(1)) && (col_q == w_eff - DimW'(1));
      if (col_q == w_eff - DimW'(1)) begin
        nxt_row = row_q + DimW'(1);
        nxt_col = '0;
      end else begin
        nxt_row = row_q;
        nxt_col = col_q + DimW'(1);
      end
    end else begin
      pass_end = (row_q == '0) && (col_q == '0);
      if (col_q == '0) begin
        nxt_row = row_q - DimW'(1);
        nxt_col = w_eff - DimW'(1);
      end else begin
        nxt_row = row_q;
        nxt_col = col_q - DimW'(1);
      end
    end
  end

  // neighbour to fetch next: up/down/left/right offsets, diagonals included, per pass
  logic [1:0]      nb_idx;
  logic            go_up, go_dn, go_lf, go_rt, nb_ok;
  logic [DimW-1:0] nb_row, nb_col;

  always_comb begin
    nb_idx = (state_q == ST_CHK) ? 2'd0 : 2'(nb_q + 2'd1);
    go_up = 1'b0;
    go_dn = 1'b0;
    go_lf = 1'b0;
    go_rt = 1'b0;
    case ({bwd_q, nb_idx})
      3'b000: begin go_up = 1'b1; go_lf = 1'b1; end
      3'b001: begin go_up = 1'b1; end
      3'b010: begin go_up = 1'b1; go_rt = 1'b1; end
      3'b011: begin go_lf = 1'b1; end
      3'b100: begin go_rt = 1'b1; end
      3'b101: begin go_dn = 1'b1; go_lf = 1'b1; end
      3'b110: begin go_dn = 1'b1; end
      default: begin go_dn = 1'b1; go_rt = 1'b1; end
    endcase
    nb_ok = !(go_up && row_q == '0) && !(go_dn && row_q == h_eff - DimW'(1)) &&
            !(go_lf && col_q == '0) && !(go_rt && col_q == w_eff - DimW'(1));
    nb_row = row_q;
    nb_col = col_q;
    if (nb_ok) begin
      if (go_up) nb_row = row_q - DimW'(1);
      if (go_dn) nb_row = row_q + DimW'(1);
      if (go_lf) nb_col = col_q - DimW'(1);
      if (go_rt) nb_col = col_q + DimW'(1);
    end
  end

  // relaxation against the neighbour value now on the read port
  logic [DistW-1:0] cand;
  logic [DistW:0]   nb_plus;

  always_comb begin
    nb_plus = {1'b0, ram_rdata} + (DistW+1)'(1);
    if (nb_ok_q && ram_rdata != FarMark && nb_plus < {1'b0, cur_q}) begin
      cand = nb_plus[DistW-1:0];
    end else begin
      cand = cur_q;
    end
  end

  logic             in_store;
  logic [DistW-1:0] chk_val;

  assign in_store = (32'(pixel_row_i) < MAX_ROWS) && (32'(pixel_col_i) < MAX_COLS);
  // forward pass normalises: any stored nonzero becomes far
  assign chk_val  = (!bwd_q && ram_rdata != '0) ? FarMark : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bwd_q     <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      nb_q      <= '0;
      nb_ok_q   <= 1'b0;
      any_fg_q  <= 1'b0;
      any_bg_q  <= 1'b0;
      best_q    <= '0;
      largest_q <= '0;
      unreach_q <= 1'b0;
      done_q    <= 1'b0;
      rd_sel_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      bwd_q     <= bwd_d;
      row_q     <= row_d;
      col_q     <= col_d;
      nb_q      <= nb_d;
      nb_ok_q   <= nb_ok_d;
      any_fg_q  <= any_fg_d;
      any_bg_q  <= any_bg_d;
      best_q    <= best_d;
      largest_q <= largest_d;
      unreach_q <= unreach_d;
      done_q    <= done_d;
      rd_sel_q  <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    state_d   = state_q;
    bwd_d     = bwd_q;
    row_d     = row_q;
    col_d     = col_q;
    nb_d      = nb_q;
    nb_ok_d   = nb_ok_q;
    cur_d     = cur_q;
    any_fg_d  = any_fg_q;
    any_bg_d  = any_bg_q;
    best_d    = best_q;
    largest_d = largest_q;
    unreach_d = unreach_q;
    done_d    = 1'b0;
    rd_sel_d  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = pix_addr(row_q, col_q);
    ram_raddr = pix_addr(row_q, col_q);
    ram_wdata = cand;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (mode_e'(mode_i))
            MODE_LOAD: begin
              ram_we    = in_store;
              ram_waddr = pix_addr(DimW'(pixel_row_i), DimW'(pixel_col_i));
              ram_wdata = (pixel_value_i != '0) ? FarMark : '0;
              done_d    = 1'b1;
            end
            MODE_READ: begin
              ram_re    = in_store;
              ram_raddr = pix_addr(DimW'(pixel_row_i), DimW'(pixel_col_i));
              rd_sel_d  = in_store;
              done_d    = 1'b1;
            end
            MODE_RUN: begin
              bwd_d    = 1'b0;
              row_d    = '0;
              col_d    = '0;
              any_fg_d = 1'b0;
              any_bg_d = 1'b0;
              best_d   = '0;
              state_d  = ST_CEN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_CEN: begin
        ram_re  = 1'b1;
        state_d = ST_CHK;
      end

      ST_CHK, ST_NB: begin
        logic advance;
        advance = 1'b0;
        if (state_q == ST_CHK) begin
          if (!bwd_q) begin
            if (chk_val == '0) any_bg_d = 1'b1;
            else               any_fg_d = 1'b1;
          end
          if (chk_val == '0) begin
            advance = 1'b1;
          end else begin
            cur_d     = chk_val;
            nb_d      = 2'd0;
            nb_ok_d   = nb_ok;
            ram_re    = 1'b1;
            ram_raddr = pix_addr(nb_row, nb_col);
            state_d   = ST_NB;
          end
        end else if (nb_q == NbLast) begin
          ram_we  = 1'b1;
          advance = 1'b1;
          if (bwd_q && cand > best_q) best_d = cand;
        end else begin
          cur_d     = cand;
          nb_d      = nb_idx;
          nb_ok_d   = nb_ok;
          ram_re    = 1'b1;
          ram_raddr = pix_addr(nb_row, nb_col);
        end

        if (advance) begin
          if (!pass_end) begin
            row_d   = nxt_row;
            col_d   = nxt_col;
            state_d = ST_CEN;
          end else if (!bwd_q) begin
            bwd_d   = 1'b1;
            row_d   = h_eff - DimW'(1);
            col_d   = w_eff - DimW'(1);
            state_d = ST_CEN;
          end else begin
            // best does not yet cover the write of the final pixel this cycle
            if (ram_we && cand > best_q) begin
              largest_d = any_bg_q ? cand : '0;
            end else begin
              largest_d = any_bg_q ? best_q : '0;
            end
            unreach_d = any_fg_q && !any_bg_q;
            done_d    = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  cdt_ram #(
    .Width (DistW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign distance_o     = rd_sel_q ? ram_rdata : '0;
  assign max_distance_o = largest_q;
  assign unreachable_o  = unreach_q;

  // a run ends with the sequencer back in idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while the sequencer is active");

  // load, read and unused modes answer in the next cycle
  a_quick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i != MODE_RUN) |=> done_o)
    else $error("missing result for a single-cycle transaction");

  a_run_no_early_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_RUN) |=> (busy && !done_o))
    else $error("run transaction did not start the sequencer");

  a_unreach_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    unreach_q |-> (largest_q == '0))
    else $error("unreachable flag with a nonzero largest distance");

  // during a run the store is written only at the end of a neighbour sweep
  a_write_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_IDLE) || (state_q == ST_NB && nb_q == NbLast)))
    else $error("store written outside a write slot");

endmodule

`default_nettype wire
